// ----- rtl/pis_pkg.sv -----
// pis_pkg: shared widths, constants, config register indexes, the arctangent
// table and the word type passed along the CORDIC cell chain.
// No dependencies.
package pis_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = 17;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int RADIUS_W   = 15;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int ANGLE_W    = 15;
  localparam int XY_W       = 40;
  localparam int Z_W        = 24;
  localparam int FRAC_SH    = 8;
  localparam int PRESCALE_SH = 20;
  localparam int ATAN_LEN   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [ANGLE_W-1:0]    FULL_CIRCLE = 15'd23040;
  localparam logic signed [Z_W-1:0] HALF_FINE   = 24'sd2949120;
  localparam logic signed [Z_W-1:0] FULL_FINE   = 24'sd5898240;
  localparam logic signed [Z_W-1:0] ROUND_HALF  = 24'sd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_RADIUS      = 3'd2,
    CFG_START_ANGLE = 3'd3,
    CFG_END_ANGLE   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic                  origin;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  // atan(2^-i) in 1/16384 degree, rounded
  function automatic logic signed [Z_W-1:0] atan_fine(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = 24'sd737280;
      1:  v = 24'sd435242;
      2:  v = 24'sd229970;
      3:  v = 24'sd116736;
      4:  v = 24'sd58595;
      5:  v = 24'sd29326;
      6:  v = 24'sd14667;
      7:  v = 24'sd7334;
      8:  v = 24'sd3667;
      9:  v = 24'sd1833;
      10: v = 24'sd917;
      11: v = 24'sd458;
      12: v = 24'sd229;
      13: v = 24'sd115;
      14: v = 24'sd57;
      15: v = 24'sd29;
      16: v = 24'sd14;
      17: v = 24'sd7;
      18: v = 24'sd4;
      19: v = 24'sd2;
      20: v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/pis_in_if.sv -----
// pis_in_if: input channel carrying one query point per word.
// Depends on pis_pkg.
interface pis_in_if;
  import pis_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ----- rtl/pis_out_if.sv -----
// pis_out_if: result channel carrying one hit flag per word.
// No dependencies.
interface pis_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

// ----- rtl/point_in_sector_test.sv -----
// point_in_sector_test: top level, config registers and the CORDIC cell chain.
// Depends on pis_pkg, pis_in_if, pis_out_if, pis_front, pis_cell, pis_finish.
//
// Tests each point word against a circular sector: squared distance from the
// center against radius squared, then the polar angle (CORDIC atan2, 1/64
// degree) against [start_angle, end_angle], wrapping through zero when start
// exceeds end. One word is accepted per clock unless the output holds the
// pipeline; each word passes three front stages, one register cell per
// CORDIC step and the output register. The whole pipeline holds while
// a result waits at the output. Configure only while no word is in flight.
module point_in_sector_test #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pis_in_if.sink                            in_if,
  pis_out_if.source                         out_if,
  input  logic                              cfg_wr_en,
  input  logic [pis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pis_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pis_pkg::*;

  localparam int NCELL = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;

  logic signed [COORD_W-1:0] center_x_r, center_y_r;
  logic [RADIUS_W-1:0]       radius_r;
  logic [ANGLE_W-1:0]        start_angle_r, end_angle_r;
  logic                      en;
  logic                      out_valid;
  cordic_t                   chain [0:NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      radius_r      <= '0;
      start_angle_r <= '0;
      end_angle_r   <= FULL_CIRCLE;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X:    center_x_r    <= signed'(cfg_wdata[COORD_W-1:0]);
        CFG_CENTER_Y:    center_y_r    <= signed'(cfg_wdata[COORD_W-1:0]);
        CFG_RADIUS:      radius_r      <= cfg_wdata[RADIUS_W-1:0];
        CFG_START_ANGLE: start_angle_r <= cfg_wdata[ANGLE_W-1:0];
        CFG_END_ANGLE:   end_angle_r   <= cfg_wdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: move unless a result is held at the output
  assign en          = !out_valid || out_if.ready;
  assign in_if.ready = en;

  pis_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_if.valid),
    .point_x  (in_if.point_x),
    .point_y  (in_if.point_y),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .radius   (radius_r),
    .out_word (chain[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    pis_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_word  (chain[g]),
      .out_word (chain[g+1])
    );
  end

  pis_finish u_finish (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_word     (chain[NCELL]),
    .start_angle (start_angle_r),
    .end_angle   (end_angle_r),
    .out_valid   (out_valid),
    .inside_res  (out_if.inside_res)
  );

  assign out_if.valid = out_valid;
endmodule

// ----- rtl/pis_front.sv -----
// pis_front: offset from center, radius test and CORDIC preload (3 stages).
// Depends on pis_pkg.
module pis_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [pis_pkg::COORD_W-1:0] point_x,
  input  logic signed [pis_pkg::COORD_W-1:0] point_y,
  input  logic signed [pis_pkg::COORD_W-1:0] center_x,
  input  logic signed [pis_pkg::COORD_W-1:0] center_y,
  input  logic [pis_pkg::RADIUS_W-1:0]       radius,
  output pis_pkg::cordic_t                   out_word
);
  import pis_pkg::*;

  logic                     v0_r, v1_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic signed [SQ_W-1:0]   dx_sq, dy_sq;
  logic [SQ_W-1:0]          dx2_r, dy2_r;
  logic [R2_W-1:0]          r2_r;
  logic                     rzero_r, origin_r;
  logic signed [XY_W-1:0]   sx, sy, x_nxt, y_nxt, x1_r, y1_r;
  logic signed [Z_W-1:0]    z_nxt, z1_r;
  logic [DIST_W-1:0]        dist2;
  cordic_t                  out_r;

  assign dx_sq = dx_r * dx_r;
  assign dy_sq = dy_r * dy_r;
  assign sx = XY_W'(dx_r) <<< PRESCALE_SH;
  assign sy = XY_W'(dy_r) <<< PRESCALE_SH;

  always_comb begin
    if (dx_r < 0) begin
      x_nxt = -sx;
      y_nxt = -sy;
      z_nxt = HALF_FINE;
    end else begin
      x_nxt = sx;
      y_nxt = sy;
      z_nxt = '0;
    end
  end

  assign dist2 = {1'b0, dx2_r} + {1'b0, dy2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      out_r.valid <= 1'b0;
    end else if (en) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      out_r.valid <= v1_r;
    end
    if (en) begin
      dx_r     <= DIFF_W'(point_x) - DIFF_W'(center_x);
      dy_r     <= DIFF_W'(point_y) - DIFF_W'(center_y);
      dx2_r    <= unsigned'(dx_sq);
      dy2_r    <= unsigned'(dy_sq);
      r2_r     <= radius * radius;
      rzero_r  <= (radius == '0);
      origin_r <= (dx_r == '0) && (dy_r == '0);
      x1_r     <= x_nxt;
      y1_r     <= y_nxt;
      z1_r     <= z_nxt;
      out_r.hit    <= !rzero_r && (dist2 <= DIST_W'(r2_r));
      out_r.origin <= origin_r;
      out_r.x      <= x1_r;
      out_r.y      <= y1_r;
      out_r.z      <= z1_r;
    end
  end

  assign out_word = out_r;
endmodule

// ----- rtl/pis_cell.sv -----
// pis_cell: one CORDIC vectoring iteration, registered, for step IDX.
// Depends on pis_pkg.
module pis_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  pis_pkg::cordic_t in_word,
  output pis_pkg::cordic_t out_word
);
  import pis_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_fine(IDX);

  logic signed [XY_W-1:0] xs, ys;
  cordic_t                nxt, out_r;

  assign xs = in_word.x >>> IDX;
  assign ys = in_word.y >>> IDX;

  always_comb begin
    nxt = in_word;
    if (!in_word.y[XY_W-1]) begin
      nxt.x = in_word.x + ys;
      nxt.y = in_word.y - xs;
      nxt.z = in_word.z + ATAN;
    end else begin
      nxt.x = in_word.x - ys;
      nxt.y = in_word.y + xs;
      nxt.z = in_word.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (en) begin
      out_r.valid <= in_word.valid;
    end
    if (en) begin
      out_r.hit    <= nxt.hit;
      out_r.origin <= nxt.origin;
      out_r.x      <= nxt.x;
      out_r.y      <= nxt.y;
      out_r.z      <= nxt.z;
    end
  end

  assign out_word = out_r;
endmodule

// ----- rtl/pis_finish.sv -----
// pis_finish: angle wrap and rounding, range compare, output register.
// Depends on pis_pkg.
module pis_finish (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  pis_pkg::cordic_t             in_word,
  input  logic [pis_pkg::ANGLE_W-1:0]  start_angle,
  input  logic [pis_pkg::ANGLE_W-1:0]  end_angle,
  output logic                         out_valid,
  output logic                         inside_res
);
  import pis_pkg::*;

  logic signed [Z_W-1:0] zp, zr;
  logic [ANGLE_W-1:0]    a_raw, ang;
  logic                  in_range;
  logic                  valid_r, inside_r;

  assign zp    = in_word.z[Z_W-1] ? in_word.z + FULL_FINE : in_word.z;
  assign zr    = zp + ROUND_HALF;
  assign a_raw = zr[ANGLE_W+FRAC_SH-1:FRAC_SH];

  always_comb begin
    if (in_word.origin || a_raw == FULL_CIRCLE) begin
      ang = '0;
    end else begin
      ang = a_raw;
    end
    if (start_angle <= end_angle) begin
      in_range = (ang >= start_angle) && (ang <= end_angle);
    end else begin
      in_range = (ang >= start_angle) || (ang <= end_angle);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside_r <= in_word.hit && in_range;
    end
  end

  assign out_valid  = valid_r;
  assign inside_res = inside_r;
endmodule
